### src/iirdf_pkg.sv
// ----------------------------------------------------------------------------
// IIR direct form I filter package
// Shared widths, codes and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package iirdf_pkg;

    localparam int COEF_W    = 32;
    localparam int HIST_W    = 24;
    localparam int SAMPLE_W  = 16;
    localparam int ORDER_W   = 5;
    localparam int INDEX_W   = 5;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [HIST_W-1:0]   HIST_MAX   = 24'sh7FFFFF;
    localparam logic signed [HIST_W-1:0]   HIST_MIN   = -24'sh800000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE   = 2'd0,
        CMD_FF_WRITE = 2'd1,
        CMD_FB_WRITE = 2'd2
    } t_command;

    localparam logic [CFG_IDX_W-1:0] CFG_FF_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_ORDER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd2;

    typedef struct packed {
        logic load_sample;
        logic ff_write;
        logic fb_write;
        logic scale_mul;
        logic x_write;
        logic tap_issue;
        logic tap_fb;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_blocked;
    } t_dp_status;

endpackage

### src/iirdf_ctrl.sv
// ----------------------------------------------------------------------------
// IIR filter controller
// Sequences one transaction at a time: coefficient writes, input scaling,
// the feed-forward and feedback tap passes and the output write-back.
// ----------------------------------------------------------------------------
module iirdf_ctrl #(
    parameter int MAX_ORDER = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic [iirdf_pkg::CMD_W-1:0]        i_command,
    input  logic [iirdf_pkg::INDEX_W-1:0]      i_coeff_index,
    input  logic [iirdf_pkg::ORDER_W-1:0]      i_ff_order,
    input  logic [iirdf_pkg::ORDER_W-1:0]      i_fb_order,
    input  iirdf_pkg::t_dp_status              i_status,
    output logic                               o_in_stall,
    output iirdf_pkg::t_dp_cmd                 o_cmd,
    output logic [$clog2(MAX_ORDER+1)-1:0]     o_hist_addr,
    output logic [$clog2(MAX_ORDER+1)-1:0]     o_coef_addr,
    output logic [$clog2(MAX_ORDER+1)-1:0]     o_xwr_addr,
    output logic [$clog2(MAX_ORDER+1)-1:0]     o_ywr_addr
);

    localparam int IW = $clog2(MAX_ORDER + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCALE = 7'b0000010,
        S_XWR   = 7'b0000100,
        S_FF    = 7'b0001000,
        S_FB    = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_ipos, n_ipos;
    logic [IW-1:0]   r_opos, n_opos;
    logic [IW-1:0]   r_m, n_m;
    logic [IW-1:0]   r_n, n_n;
    logic [IW-1:0]   r_j, n_j;
    logic [IW-1:0]   r_k, n_k;
    logic [IW-1:0]   m_clamped;
    logic [IW-1:0]   n_clamped;
    logic            ff_ok;
    logic            fb_ok;

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] pos,
                                                input logic [IW-1:0] last);
        ring_next = (pos >= last) ? '0 : IW'(pos + IW'(1));
    endfunction

    assign m_clamped = (int'(i_ff_order) > MAX_ORDER) ? IW'(MAX_ORDER) : IW'(i_ff_order);
    assign n_clamped = (int'(i_fb_order) > MAX_ORDER) ? IW'(MAX_ORDER) : IW'(i_fb_order);
    assign ff_ok     = (int'(i_coeff_index) <= MAX_ORDER);
    assign fb_ok     = (int'(i_coeff_index) < MAX_ORDER);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_hist_addr = r_j;
    assign o_coef_addr = r_k;
    assign o_xwr_addr  = r_ipos;
    assign o_ywr_addr  = r_opos;

    always_comb begin
        n_state = r_state;
        n_ipos  = r_ipos;
        n_opos  = r_opos;
        n_m     = r_m;
        n_n     = r_n;
        n_j     = r_j;
        n_k     = r_k;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_command)
                        iirdf_pkg::CMD_SAMPLE: begin
                            o_cmd.load_sample = 1'b1;
                            n_m     = m_clamped;
                            n_n     = n_clamped;
                            n_ipos  = ring_next(r_ipos, m_clamped);
                            n_opos  = ring_next(r_opos, n_clamped);
                            n_state = S_SCALE;
                        end
                        iirdf_pkg::CMD_FF_WRITE: begin
                            o_cmd.ff_write = ff_ok;
                        end
                        iirdf_pkg::CMD_FB_WRITE: begin
                            o_cmd.fb_write = fb_ok;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCALE: begin
                o_cmd.scale_mul = 1'b1;
                n_state = S_XWR;
            end
            S_XWR: begin
                o_cmd.x_write = 1'b1;
                n_j     = ring_next(r_ipos, r_m);
                n_k     = '0;
                n_state = S_FF;
            end
            S_FF: begin
                o_cmd.tap_issue = 1'b1;
                if (r_k == r_m) begin
                    n_j     = ring_next(r_opos, r_n);
                    n_k     = '0;
                    n_state = (r_n == '0) ? S_DRAIN : S_FB;
                end else begin
                    n_j = ring_next(r_j, r_m);
                    n_k = IW'(r_k + IW'(1));
                end
            end
            S_FB: begin
                o_cmd.tap_issue = 1'b1;
                o_cmd.tap_fb    = 1'b1;
                if (IW'(r_k + IW'(1)) == r_n) begin
                    n_state = S_DRAIN;
                end else begin
                    n_j = ring_next(r_j, r_n);
                    n_k = IW'(r_k + IW'(1));
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_status.out_blocked) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ipos  <= '0;
            r_opos  <= '0;
            r_m     <= '0;
            r_n     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_ipos  <= n_ipos;
            r_opos  <= n_opos;
            r_m     <= n_m;
            r_n     <= n_n;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

endmodule

### src/iirdf_dp.sv
// ----------------------------------------------------------------------------
// IIR filter datapath
// Coefficient and history memories, one shared multiplier, the accumulator,
// the rounding and saturation stage and the output register.
// ----------------------------------------------------------------------------
module iirdf_dp #(
    parameter int MAX_ORDER      = 16,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  iirdf_pkg::t_dp_cmd                        i_cmd,
    input  logic [$clog2(MAX_ORDER+1)-1:0]            i_hist_addr,
    input  logic [$clog2(MAX_ORDER+1)-1:0]            i_coef_addr,
    input  logic [$clog2(MAX_ORDER+1)-1:0]            i_xwr_addr,
    input  logic [$clog2(MAX_ORDER+1)-1:0]            i_ywr_addr,
    input  logic signed [iirdf_pkg::COEF_W-1:0]       i_gain,
    input  logic signed [iirdf_pkg::SAMPLE_W-1:0]     i_sample_in,
    input  logic [iirdf_pkg::INDEX_W-1:0]             i_coeff_index,
    input  logic signed [iirdf_pkg::COEF_W-1:0]       i_coeff_value,
    input  logic                                      i_out_stall,
    output iirdf_pkg::t_dp_status                     o_status,
    output logic                                      o_out_valid,
    output logic signed [iirdf_pkg::SAMPLE_W-1:0]     o_sample_out,
    output logic                                      o_saturated
);

    localparam int IW    = $clog2(MAX_ORDER + 1);
    localparam int FBW   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int DEPTH = MAX_ORDER + 1;
    localparam int CW    = iirdf_pkg::COEF_W;
    localparam int HW    = iirdf_pkg::HIST_W;
    localparam int SW    = iirdf_pkg::SAMPLE_W;
    localparam int PW    = CW + HW;
    localparam int ACC_W = PW + $clog2(2 * MAX_ORDER + 1) + 1;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] HMAX_X     = ACC_W'(iirdf_pkg::HIST_MAX);
    localparam logic signed [ACC_W-1:0] HMIN_X     = ACC_W'(iirdf_pkg::HIST_MIN);
    localparam logic signed [HW-1:0]    SMAX_H     = HW'(iirdf_pkg::SAMPLE_MAX);
    localparam logic signed [HW-1:0]    SMIN_H     = HW'(iirdf_pkg::SAMPLE_MIN);

    logic signed [CW-1:0] ff_mem [DEPTH];
    logic signed [CW-1:0] fb_mem [MAX_ORDER];
    logic signed [HW-1:0] xh_mem [DEPTH];
    logic signed [HW-1:0] yh_mem [DEPTH];

    logic [DEPTH-1:0]     r_ff_vld;
    logic [MAX_ORDER-1:0] r_fb_vld;
    logic [DEPTH-1:0]     r_xh_vld;
    logic [DEPTH-1:0]     r_yh_vld;

    logic signed [CW-1:0] r_ff_rd;
    logic signed [CW-1:0] r_fb_rd;
    logic signed [HW-1:0] r_xh_rd;
    logic signed [HW-1:0] r_yh_rd;
    logic                 r_ff_rd_vld;
    logic                 r_fb_rd_vld;
    logic                 r_xh_rd_vld;
    logic                 r_yh_rd_vld;
    logic                 r_sel_fb;
    logic                 r_rd_valid;

    logic signed [SW-1:0]    r_x;
    logic signed [PW-1:0]    r_prod;
    logic                    r_p_valid;
    logic signed [ACC_W-1:0] r_acc;

    logic                    r_out_valid;
    logic signed [SW-1:0]    r_sample_out;
    logic                    r_saturated;

    logic [IW-1:0]           ff_waddr;
    logic [FBW-1:0]          fb_waddr;
    logic [FBW-1:0]          fb_raddr;
    logic signed [CW-1:0]    coef_op;
    logic signed [HW-1:0]    data_op;
    logic signed [CW-1:0]    mul_a;
    logic signed [HW-1:0]    mul_b;
    logic signed [PW-1:0]    mul_p;
    logic signed [ACC_W-1:0] rs_in;
    logic signed [ACC_W-1:0] rs_sum;
    logic signed [ACC_W-1:0] rs_shift;
    logic signed [HW-1:0]    rescaled;

    assign ff_waddr = IW'(i_coeff_index);
    assign fb_waddr = FBW'(i_coeff_index);
    assign fb_raddr = FBW'(i_coef_addr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ff_write) begin
            ff_mem[ff_waddr] <= i_coeff_value;
        end
        r_ff_rd <= ff_mem[i_coef_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fb_write) begin
            fb_mem[fb_waddr] <= i_coeff_value;
        end
        r_fb_rd <= fb_mem[fb_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.x_write) begin
            xh_mem[i_xwr_addr] <= rescaled;
        end
        r_xh_rd <= xh_mem[i_hist_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            yh_mem[i_ywr_addr] <= rescaled;
        end
        r_yh_rd <= yh_mem[i_hist_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff_vld <= '0;
            r_fb_vld <= '0;
            r_xh_vld <= '0;
            r_yh_vld <= '0;
        end else begin
            if (i_cmd.ff_write) begin
                r_ff_vld[ff_waddr] <= 1'b1;
            end
            if (i_cmd.fb_write) begin
                r_fb_vld[fb_waddr] <= 1'b1;
            end
            if (i_cmd.x_write) begin
                r_xh_vld[i_xwr_addr] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_yh_vld[i_ywr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ff_rd_vld <= r_ff_vld[i_coef_addr];
        r_fb_rd_vld <= r_fb_vld[fb_raddr];
        r_xh_rd_vld <= r_xh_vld[i_hist_addr];
        r_yh_rd_vld <= r_yh_vld[i_hist_addr];
        r_sel_fb    <= i_cmd.tap_fb;
        if (i_cmd.load_sample) begin
            r_x <= i_sample_in;
        end
    end

    always_comb begin
        if (r_sel_fb) begin
            coef_op = r_fb_rd_vld ? r_fb_rd : '0;
            data_op = r_yh_rd_vld ? r_yh_rd : '0;
        end else begin
            coef_op = r_ff_rd_vld ? r_ff_rd : '0;
            data_op = r_xh_rd_vld ? r_xh_rd : '0;
        end
    end

    assign mul_a = i_cmd.scale_mul ? i_gain : coef_op;
    assign mul_b = i_cmd.scale_mul ? HW'(r_x) : data_op;
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (i_cmd.load_sample) begin
            r_acc <= '0;
        end else if (r_p_valid) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    always_comb begin
        rs_in    = i_cmd.x_write ? ACC_W'(r_prod) : r_acc;
        rs_sum   = rs_in + ROUND_HALF;
        rs_shift = rs_sum >>> COEF_FRAC_BITS;
        if (rs_shift > HMAX_X) begin
            rescaled = iirdf_pkg::HIST_MAX;
        end else if (rs_shift < HMIN_X) begin
            rescaled = iirdf_pkg::HIST_MIN;
        end else begin
            rescaled = rs_shift[HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (rescaled > SMAX_H) begin
                r_sample_out <= iirdf_pkg::SAMPLE_MAX;
                r_saturated  <= 1'b1;
            end else if (rescaled < SMIN_H) begin
                r_sample_out <= iirdf_pkg::SAMPLE_MIN;
                r_saturated  <= 1'b1;
            end else begin
                r_sample_out <= rescaled[SW-1:0];
                r_saturated  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.tap_issue;
            r_p_valid  <= r_rd_valid;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.pipe_busy   = r_rd_valid | r_p_valid;
    assign o_status.out_blocked = r_out_valid & i_out_stall;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_saturated  = r_saturated;

endmodule

### src/iir_direct_form_filter.sv
// ----------------------------------------------------------------------------
// IIR direct form I filter
// Fixed-point direct form I filter with Q8.24 coefficients, Q9.15 histories
// and a saturated Q1.15 output.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_in_valid / o_in_stall) carries one transaction
// per command. A sample transaction produces exactly one output transaction
// on i_out_stall / o_out_valid; coefficient writes and the unused command
// produce none and are absorbed in the cycle they are accepted.
// A sample is scaled by the gain register, written to the input history, and
// then the feed-forward (M + 1) and feedback (N) taps pass one at a time
// through a single multiplier and accumulator, fed from registered memory
// reads. The output is offered in the same cycle in which the next transaction
// can first be accepted; the block takes no new transaction while a sample is
// still in work.
// The result sits in an output register; while the receiver stalls, the
// block keeps accepting and working on the next transaction and holds only
// its final write-back until the register is free.
// Reset clears the configuration to orders of zero and unity gain, and all
// coefficients and histories read as zero until written.
// Configuration registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
module iir_direct_form_filter #(
    parameter int MAX_ORDER      = 16,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [iirdf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [iirdf_pkg::COEF_W-1:0]           i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [iirdf_pkg::CMD_W-1:0]            i_command,
    input  logic signed [iirdf_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  logic [iirdf_pkg::INDEX_W-1:0]          i_coeff_index,
    input  logic signed [iirdf_pkg::COEF_W-1:0]    i_coeff_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [iirdf_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                   o_saturated
);

    localparam int IW = $clog2(MAX_ORDER + 1);
    localparam int CW = iirdf_pkg::COEF_W;
    localparam int OW = iirdf_pkg::ORDER_W;
    localparam logic signed [CW-1:0] GAIN_ONE = CW'(1) << COEF_FRAC_BITS;

    logic [OW-1:0]          r_ff_order;
    logic [OW-1:0]          r_fb_order;
    logic signed [CW-1:0]   r_gain;

    iirdf_pkg::t_dp_cmd     dp_cmd;
    iirdf_pkg::t_dp_status  dp_status;
    logic [IW-1:0]          hist_addr;
    logic [IW-1:0]          coef_addr;
    logic [IW-1:0]          xwr_addr;
    logic [IW-1:0]          ywr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff_order <= '0;
            r_fb_order <= '0;
            r_gain     <= GAIN_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                iirdf_pkg::CFG_FF_ORDER: r_ff_order <= i_cfg_data[OW-1:0];
                iirdf_pkg::CFG_FB_ORDER: r_fb_order <= i_cfg_data[OW-1:0];
                iirdf_pkg::CFG_GAIN:     r_gain     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    iirdf_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_command     (i_command),
        .i_coeff_index (i_coeff_index),
        .i_ff_order    (r_ff_order),
        .i_fb_order    (r_fb_order),
        .i_status      (dp_status),
        .o_in_stall    (o_in_stall),
        .o_cmd         (dp_cmd),
        .o_hist_addr   (hist_addr),
        .o_coef_addr   (coef_addr),
        .o_xwr_addr    (xwr_addr),
        .o_ywr_addr    (ywr_addr)
    );

    iirdf_dp #(
        .MAX_ORDER      (MAX_ORDER),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_hist_addr   (hist_addr),
        .i_coef_addr   (coef_addr),
        .i_xwr_addr    (xwr_addr),
        .i_ywr_addr    (ywr_addr),
        .i_gain        (r_gain),
        .i_sample_in   (i_sample_in),
        .i_coeff_index (i_coeff_index),
        .i_coeff_value (i_coeff_value),
        .i_out_stall   (i_out_stall),
        .o_status      (dp_status),
        .o_out_valid   (o_out_valid),
        .o_sample_out  (o_sample_out),
        .o_saturated   (o_saturated)
    );

endmodule
